### rtl/fjg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjg_pkg
// Types and constants shared by the feeder jam guard.
// ----------------------------------------------------------------------------
package fjg_pkg;

  localparam int unsigned AngleW   = 32;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned TargetW  = 34;
  localparam int unsigned DiffW    = 36;
  localparam int unsigned StepW    = 20;
  localparam int unsigned TolW     = 20;
  localparam int unsigned StallSpW = 15;
  localparam int unsigned TimerW   = 16;
  localparam int unsigned CfgAddrW = 8;
  localparam int unsigned CfgDataW = 20;

  // register map
  localparam logic [CfgAddrW-1:0] REG_STEP_ANGLE     = 8'd0;
  localparam logic [CfgAddrW-1:0] REG_NEAR_TOLERANCE = 8'd1;
  localparam logic [CfgAddrW-1:0] REG_STALL_SPEED    = 8'd2;
  localparam logic [CfgAddrW-1:0] REG_STALL_TIMEOUT  = 8'd3;

  // reset values
  localparam logic [StepW-1:0]    STEP_ANGLE_RST     = 20'd36864;
  localparam logic [TolW-1:0]     NEAR_TOLERANCE_RST = 20'd368;
  localparam logic [StallSpW-1:0] STALL_SPEED_RST    = 15'd80;
  localparam logic [TimerW-1:0]   STALL_TIMEOUT_RST  = 16'd3000;

  typedef enum logic [1:0] {
    MODE_SHUT   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_CONT   = 2'd2,
    MODE_NONE   = 2'd3
  } fire_mode_e;

  typedef struct packed {
    logic [StepW-1:0]    step_angle;
    logic [TolW-1:0]     near_tolerance;
    logic [StallSpW-1:0] stall_speed;
    logic [TimerW-1:0]   stall_timeout;
  } cfg_t;

  typedef struct packed {
    logic signed [TargetW-1:0] target;
    logic                      first_done;
    logic [TimerW-1:0]         stall_timer;
    logic                      jam_flag;
    logic                      shot_lock;
    logic                      shot_count;
  } state_t;

  typedef struct packed {
    logic signed [AngleW-1:0] angle_now;
    logic signed [SpeedW-1:0] motor_speed;
    logic [1:0]               fire_mode;
  } item_t;

  typedef struct packed {
    logic signed [TargetW-1:0] target_angle;
    logic                      jam_now;
    logic                      reversing;
  } result_t;

endpackage

### rtl/fjg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjg channel interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface fjg_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_now;
  logic signed [15:0] motor_speed;
  logic [1:0]         fire_mode;

  modport source (output valid, angle_now, motor_speed, fire_mode, input ready);
  modport sink   (input valid, angle_now, motor_speed, fire_mode, output ready);
endinterface

interface fjg_out_if;
  logic               valid;
  logic               ready;
  logic signed [33:0] target_angle;
  logic               jam_now;
  logic               reversing;

  modport source (output valid, target_angle, jam_now, reversing, input ready);
  modport sink   (input valid, target_angle, jam_now, reversing, output ready);
endinterface

interface fjg_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  addr;
  logic [19:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

### rtl/feeder_jam_guard_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feeder_jam_guard_core
// Feeder jam guard: per-tick target angle, stall timer and jam recovery.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   - one item per control tick: angle_now, motor_speed, fire_mode.
//   out_o  - exactly one result item per input item: target_angle,
//            jam_now, reversing.
//   cfg_i  - register writes (addr 0 step_angle, 1 near_tolerance,
//            2 stall_speed, 3 stall_timeout); other addresses are ignored.
//            Always ready; write only while no item is in flight.
// Timing:
//   An accepted item lands in an input register, the update logic runs on
//   it and the result is captured in the output register when that
//   register is free or drained. One item per cycle sustained while out_o
//   is ready; state (target, timer, flags) is registered with the result.
// Reset:
//   Clears all tick state and loads the register defaults; the first item
//   after reset seeds the target with the current angle.
// Backpressure:
//   When out_o stalls the output register holds its result and the input
//   register still takes one more item; in_i.ready then drops until the
//   result is taken. Items are never dropped or repeated.
// ----------------------------------------------------------------------------
module feeder_jam_guard_core
  import fjg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  fjg_in_if.sink    in_i,
  fjg_out_if.source out_o,
  fjg_cfg_if.sink   cfg_i
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  item_t   item_q;
  result_t res_q;
  result_t res_d;
  logic    in_valid_q;
  logic    out_valid_q;
  logic    advance;
  logic    in_take;

  // an item moves from the input register to the output register when the
  // output side is free or being drained this cycle
  assign advance   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take   = in_i.valid && in_i.ready;

  assign cfg_i.ready = 1'b1;

  fjg_update u_update (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // control and tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      state_q              <= '0;
      cfg_q.step_angle     <= STEP_ANGLE_RST;
      cfg_q.near_tolerance <= NEAR_TOLERANCE_RST;
      cfg_q.stall_speed    <= STALL_SPEED_RST;
      cfg_q.stall_timeout  <= STALL_TIMEOUT_RST;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_i.valid) begin
        case (cfg_i.addr)
          REG_STEP_ANGLE:     cfg_q.step_angle     <= cfg_i.data[StepW-1:0];
          REG_NEAR_TOLERANCE: cfg_q.near_tolerance <= cfg_i.data[TolW-1:0];
          REG_STALL_SPEED:    cfg_q.stall_speed    <= cfg_i.data[StallSpW-1:0];
          REG_STALL_TIMEOUT:  cfg_q.stall_timeout  <= cfg_i.data[TimerW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.angle_now   <= in_i.angle_now;
      item_q.motor_speed <= in_i.motor_speed;
      item_q.fire_mode   <= in_i.fire_mode;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.target_angle = res_q.target_angle;
  assign out_o.jam_now      = res_q.jam_now;
  assign out_o.reversing    = res_q.reversing;

endmodule

### rtl/fjg_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fjg_update
// One control tick: jam check and target update, pure combinational.
// ----------------------------------------------------------------------------
module fjg_update
  import fjg_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic signed [TargetW-1:0] angle_ext;
  logic signed [TargetW-1:0] step_ext;
  logic signed [TargetW-1:0] base_target;
  logic signed [DiffW-1:0]   diff;
  logic [DiffW-1:0]          err_mag;
  logic [SpeedW:0]           speed_ext;
  logic [SpeedW:0]           speed_mag;
  logic                      near;
  logic                      stalled;
  logic                      jam;
  logic                      jam_flag_c;
  logic                      lock_c;
  logic                      count_c;
  state_t                    nxt;

  assign angle_ext   = TargetW'(item_i.angle_now);
  assign step_ext    = signed'({{(TargetW-StepW){1'b0}}, cfg_i.step_angle});
  // first tick loads the target from the current angle
  assign base_target = state_i.first_done ? state_i.target : angle_ext;
  assign diff        = DiffW'(base_target) - DiffW'(item_i.angle_now);
  assign err_mag     = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign near        = err_mag <= {{(DiffW-TolW){1'b0}}, cfg_i.near_tolerance};
  assign speed_ext   = (SpeedW+1)'(item_i.motor_speed);
  assign speed_mag   = item_i.motor_speed[SpeedW-1] ? (SpeedW+1)'(-speed_ext) : speed_ext;
  assign stalled     = !near &&
                       (speed_mag <= {{(SpeedW+1-StallSpW){1'b0}}, cfg_i.stall_speed});
  assign jam         = stalled && (state_i.stall_timer >= cfg_i.stall_timeout);
  assign jam_flag_c  = near ? 1'b0 : state_i.jam_flag;

  always_comb begin
    nxt            = state_i;
    nxt.first_done = 1'b1;
    nxt.target     = base_target;
    nxt.jam_flag   = jam_flag_c;
    lock_c         = state_i.shot_lock;
    count_c        = state_i.shot_count;

    if (stalled) begin
      if (!jam) begin
        nxt.stall_timer = state_i.stall_timer + 1'b1;
      end
    end else if (!jam_flag_c) begin
      nxt.stall_timer = '0;
    end

    if (jam) begin
      nxt.jam_flag    = 1'b1;
      nxt.stall_timer = '0;
      nxt.shot_count  = 1'b0;
      if (item_i.fire_mode == MODE_SHUT) begin
        nxt.target = angle_ext;
      end else begin
        nxt.target = angle_ext - step_ext;
      end
    end else begin
      if (item_i.fire_mode == MODE_SHUT) begin
        lock_c  = 1'b0;
        count_c = 1'b0;
      end
      if (!jam_flag_c && !lock_c) begin
        if (item_i.fire_mode == MODE_CONT) begin
          count_c = 1'b1;
        end else if (item_i.fire_mode == MODE_SINGLE) begin
          count_c = 1'b1;
          lock_c  = 1'b1;
        end
        nxt.target = count_c ? (angle_ext + step_ext) : angle_ext;
      end
      nxt.shot_lock  = lock_c;
      nxt.shot_count = count_c;
    end
  end

  assign state_o               = nxt;
  assign result_o.target_angle = nxt.target;
  assign result_o.jam_now      = jam;
  assign result_o.reversing    = nxt.jam_flag;

endmodule
